// ===== sv/fdl_pkg.sv =====
// ============================================================================
// fdl_pkg - shared types and constants for the fractional delay line
// Sizes of the sample store, field widths, register and request codes, and
// the one-hot state encoding of the sequencer.
// ============================================================================
package fdl_pkg;

    localparam int LINE_DEPTH  = 4096;
    localparam int ADDR_BITS   = $clog2(LINE_DEPTH);
    localparam int LEN_BITS    = ADDR_BITS + 1;
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int DELAY_BITS  = 28;
    localparam int ACC_BITS    = 32;
    localparam int PROD_BITS   = ACC_BITS + FRAC_BITS + 1;
    localparam int DIV_BITS    = 30;
    localparam int MIN_LEN     = 8;

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // interpolation modes
    localparam logic MODE_LINEAR   = 1'b0;
    localparam logic MODE_LAGRANGE = 1'b1;

    // register index (taken from paddr[2])
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_LEN  = 1'b1;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_TAP   = 8'b0000_0100,
        ST_COEF  = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_ACC   = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

endpackage

// ===== sv/fractional_delay_line.sv =====
// ============================================================================
// fractional_delay_line - circular sample store with interpolated reads
// Write items store a Q1.23 sample and advance the write position; read items
// return a linearly or 4th-order Lagrange interpolated sample at a fractional
// delay; a small sequencer runs the polynomial on one shared multiplier.
// ============================================================================
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------
//  input     | in        | in_valid / in_stall     | req_type, sample_in, delay_amount
//  output    | out       | out_valid / out_stall   | sample_out, delay_clamped
//  config    | in        | psel/penable/pwrite     | paddr, pwdata, prdata, pready
//
//  A write item is written to the store as it is accepted. A Lagrange read
//  makes five tap reads through the one-port store, four passes over the
//  shared 32x17 multiplier, and one reciprocal multiply for the divide by three.
//  After reset the store is cleared one entry per cycle, all LINE_DEPTH (4096)
//  entries, with in_stall high; config writes are taken then. The finished
//  result sits in an output register; a stalled output holds the sequencer in
//  its last step until the item is taken.
//
module fractional_delay_line
    import fdl_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic        [DELAY_BITS-1:0]  delay_amount,
    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          delay_clamped,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam logic signed [PROD_BITS-1:0] RND_HALF  = PROD_BITS'(1 << (FRAC_BITS - 1));
    localparam logic signed [PROD_BITS-1:0] RND_24    = PROD_BITS'(12 << FRAC_BITS);
    localparam logic        [DIV_BITS-1:0]  DIV_OFS   = DIV_BITS'(3 << (DIV_BITS - 2));
    localparam logic signed [ACC_BITS-1:0]  Q_OFS     = ACC_BITS'(1 << (DIV_BITS - 2));
    localparam logic signed [ACC_BITS-1:0]  SAT_HI    = ACC_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS-1:0]  SAT_LO    = -SAT_HI - ACC_BITS'(1);
    // ceil(2^33 / 3): floor(z / 3) = (z * RECIP3) >> 33 for any z below 2^32
    localparam logic        [31:0]          RECIP3    = 32'hAAAA_AAAB;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                         state_reg, state_next;
    logic                           mode_reg;
    logic [LEN_BITS-1:0]            len_reg;
    logic [ADDR_BITS-1:0]           wp_reg;
    logic [ADDR_BITS-1:0]           clr_reg;
    logic [2:0]                     cnt_reg;
    logic [1:0]                     hstep_reg;
    logic [ADDR_BITS-1:0]           age_reg;
    logic [FRAC_BITS-1:0]           frac_reg;
    logic                           clamp_reg;
    logic signed [SAMPLE_BITS-1:0]  tap_reg [5];
    logic signed [SAMPLE_BITS-1:0]  rdata_reg;
    logic signed [ACC_BITS-1:0]     c1_reg, c2_reg, c3_reg, acc_reg;
    logic signed [PROD_BITS-1:0]    prod_reg;
    logic [DIV_BITS-1:0]            q_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]  sample_out_reg;
    logic                           clamped_out_reg;

    logic [SAMPLE_BITS-1:0]         mem [LINE_DEPTH];

    // ------------------------------------------------------------------
    // Handshake and config port
    // ------------------------------------------------------------------
    logic in_acc, cfg_wr, out_free;

    assign in_acc   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign out_free = !out_valid_reg || !out_stall;

    assign prdata = (paddr[2] == REG_LEN) ? {{(32-LEN_BITS){1'b0}}, len_reg}
                                          : {31'b0, mode_reg};

    // clamp the length write to [MIN_LEN, LINE_DEPTH]
    logic [LEN_BITS-1:0] len_wr;
    always_comb
    begin
        len_wr = pwdata[LEN_BITS-1:0];
        if (len_wr < LEN_BITS'(MIN_LEN))
            len_wr = LEN_BITS'(MIN_LEN);
        else if (len_wr > LEN_BITS'(LINE_DEPTH))
            len_wr = LEN_BITS'(LINE_DEPTH);
    end

    // ------------------------------------------------------------------
    // Delay clamp on accept
    // ------------------------------------------------------------------
    logic [DELAY_BITS:0]   d_lo, d_hi, d_in, d_cl;
    logic                  d_flag;
    logic [ADDR_BITS-1:0]  whole;

    always_comb
    begin
        d_lo = (DELAY_BITS+1)'(mode_reg ? 3 : 1) << FRAC_BITS;
        d_hi = (DELAY_BITS+1)'(len_reg - LEN_BITS'(mode_reg ? 3 : 2)) << FRAC_BITS;
        d_in = {1'b0, delay_amount};
        d_flag = 1'b0;
        d_cl = d_in;
        if (d_in < d_lo)
        begin
            d_cl = d_lo;
            d_flag = 1'b1;
        end
        else if (d_in > d_hi)
        begin
            d_cl = d_hi;
            d_flag = 1'b1;
        end
        whole = d_cl[FRAC_BITS +: ADDR_BITS];
    end

    // ------------------------------------------------------------------
    // Store addressing: slot = wp - age, wrapped by the line length
    // ------------------------------------------------------------------
    logic [ADDR_BITS:0]   diff, wrapped;
    logic [ADDR_BITS-1:0] raddr;
    logic [ADDR_BITS:0]   wp_inc;

    always_comb
    begin
        diff    = {1'b0, wp_reg} - {1'b0, age_reg};
        wrapped = diff + len_reg;
        raddr   = diff[ADDR_BITS] ? wrapped[ADDR_BITS-1:0] : diff[ADDR_BITS-1:0];
        wp_inc  = {1'b0, wp_reg} + (ADDR_BITS+1)'(1);
    end

    logic                   mem_we;
    logic [ADDR_BITS-1:0]   waddr;
    logic [SAMPLE_BITS-1:0] wdata;

    always_comb
    begin
        mem_we = 1'b0;
        waddr  = wp_reg;
        wdata  = sample_in;
        if (state_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
            waddr  = clr_reg;
            wdata  = '0;
        end
        else if (in_acc && req_type == REQ_WRITE)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // ------------------------------------------------------------------
    // Shared arithmetic
    // ------------------------------------------------------------------
    logic signed [ACC_BITS-1:0]  xm2, xm1, x0, x1, x2;
    logic signed [ACC_BITS-1:0]  e1, o1, e2, o2, c1, c2, c3, c4, lin_diff;
    logic signed [FRAC_BITS:0]   f_s;
    logic signed [PROD_BITS-1:0] prod_rnd, prod_div;
    logic signed [ACC_BITS-1:0]  rnd32, coef_sel;
    logic [DIV_BITS-1:0]         z_cur;
    logic [DIV_BITS+32:0]        q_prod;
    logic signed [ACC_BITS-1:0]  res_raw, res_sat;

    always_comb
    begin
        xm2 = ACC_BITS'(tap_reg[0]);
        xm1 = ACC_BITS'(tap_reg[1]);
        x0  = ACC_BITS'(tap_reg[2]);
        x1  = ACC_BITS'(tap_reg[3]);
        x2  = ACC_BITS'(tap_reg[4]);
        e1 = x1 + xm1;
        o1 = x1 - xm1;
        e2 = x2 + xm2;
        o2 = x2 - xm2;
        c1 = (o1 <<< 4) - (o2 <<< 1);
        c2 = (e1 <<< 4) - e2 - (x0 <<< 5) + (x0 <<< 1);
        c3 = (o2 <<< 1) - (o1 <<< 2);
        c4 = e2 - (e1 <<< 2) + (x0 <<< 2) + (x0 <<< 1);
        // linear mode: a = tap_reg[3], b = tap_reg[4]
        lin_diff = x2 - x1;

        f_s = {1'b0, frac_reg};

        prod_rnd = prod_reg + RND_HALF;
        rnd32    = prod_rnd[FRAC_BITS +: ACC_BITS];

        case (hstep_reg)
            2'd0:    coef_sel = c3_reg;
            2'd1:    coef_sel = c2_reg;
            default: coef_sel = c1_reg;
        endcase

        // divide by 24 * 2^16 = 3 * 2^19: shift, offset positive, divide by 3
        prod_div = prod_reg + RND_24;
        z_cur    = prod_div[FRAC_BITS+3 +: DIV_BITS] + DIV_OFS;
        // divide by 3 through the reciprocal
        q_prod   = z_cur * RECIP3;

        if (mode_reg == MODE_LAGRANGE)
            res_raw = x0 + ACC_BITS'(q_reg) - Q_OFS;
        else
            res_raw = x1 + rnd32;

        if (res_raw > SAT_HI)
            res_sat = SAT_HI;
        else if (res_raw < SAT_LO)
            res_sat = SAT_LO;
        else
            res_sat = res_raw;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic [2:0] n_taps;
    assign n_taps = (mode_reg == MODE_LAGRANGE) ? 3'd5 : 3'd2;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_reg == ADDR_BITS'(LINE_DEPTH - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_acc && req_type == REQ_READ)
                    state_next = ST_TAP;
            ST_TAP:
                if (cnt_reg == n_taps)
                    state_next = ST_COEF;
            ST_COEF:
                state_next = ST_MUL;
            ST_MUL:
                if (mode_reg == MODE_LINEAR)
                    state_next = ST_DONE;
                else if (hstep_reg == 2'd3)
                    state_next = ST_DIV;
                else
                    state_next = ST_ACC;
            ST_ACC:
                state_next = ST_MUL;
            ST_DIV:
                state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            mode_reg      <= MODE_LINEAR;
            len_reg       <= LEN_BITS'(LINE_DEPTH);
            wp_reg        <= '0;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            hstep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + ADDR_BITS'(1);

            // advance the write head, wrap at the line length
            if (in_acc && req_type == REQ_WRITE)
                wp_reg <= (wp_inc == len_reg) ? '0 : wp_inc[ADDR_BITS-1:0];

            if (cfg_wr)
            begin
                if (paddr[2] == REG_MODE)
                    mode_reg <= pwdata[0];
                else
                begin
                    len_reg <= len_wr;
                    wp_reg  <= '0;
                end
            end

            if (in_acc)
                cnt_reg <= '0;
            else if (state_reg == ST_TAP)
                cnt_reg <= cnt_reg + 3'd1;

            if (state_reg == ST_COEF)
                hstep_reg <= '0;
            else if (state_reg == ST_ACC)
                hstep_reg <= hstep_reg + 2'd1;

            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            age_reg   <= (mode_reg == MODE_LAGRANGE) ? whole - ADDR_BITS'(2) : whole;
            frac_reg  <= d_cl[FRAC_BITS-1:0];
            clamp_reg <= d_flag;
        end

        if (state_reg == ST_TAP)
        begin
            age_reg <= age_reg + ADDR_BITS'(1);
            // shift in the tap read on the previous cycle
            if (cnt_reg != 3'd0)
            begin
                tap_reg[0] <= tap_reg[1];
                tap_reg[1] <= tap_reg[2];
                tap_reg[2] <= tap_reg[3];
                tap_reg[3] <= tap_reg[4];
                tap_reg[4] <= rdata_reg;
            end
        end

        if (state_reg == ST_COEF)
        begin
            c1_reg  <= c1;
            c2_reg  <= c2;
            c3_reg  <= c3;
            acc_reg <= (mode_reg == MODE_LAGRANGE) ? c4 : lin_diff;
        end

        if (state_reg == ST_MUL)
            prod_reg <= acc_reg * f_s;

        if (state_reg == ST_ACC)
            acc_reg <= rnd32 + coef_sel;

        if (state_reg == ST_DIV)
            q_reg <= q_prod[33 +: DIV_BITS];

        if (state_reg == ST_DONE && out_free)
        begin
            sample_out_reg  <= res_sat[SAMPLE_BITS-1:0];
            clamped_out_reg <= clamp_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;
    assign delay_clamped = clamped_out_reg;

endmodule
